[sv/nenc_pkg.sv]
// shared types and constants for the normal equations nonzero count block
package nenc_pkg;

  localparam int ROW_W     = 10;
  localparam int COL_W     = 10;
  localparam int TOTAL_W   = 11;
  localparam int CAP_W     = 20;
  localparam int NZ_W      = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TOTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_ENABLED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_LIMIT    = 2'd3;

  localparam logic [TOTAL_W-1:0] ROW_TOTAL_RESET    = 11'd1024;
  localparam logic [TOTAL_W-1:0] COLUMN_TOTAL_RESET = 11'd1024;

  typedef struct packed {
    logic             has_entry;
    logic [ROW_W-1:0] entry_row;
    logic [COL_W-1:0] entry_column;
    logic             column_skipped;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [NZ_W-1:0] nonzeros;
    logic            cap_exceeded;
    logic            exact;
  } result_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] row_total;
    logic [TOTAL_W-1:0] column_total;
    logic               cap_enabled;
    logic [CAP_W-1:0]   cap_limit;
  } cfg_t;

  typedef struct packed {
    logic             store;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             skip;
    logic             last;
  } queue_item_t;

endpackage

[sv/nenc_front.sv]
// front end: accepts items, checks their range and queues them for the engine
module nenc_front import nenc_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  input  cfg_t        cfg,
  input  logic        clearing,
  output logic        q_valid,
  output queue_item_t q_item,
  input  logic        q_pop
);

  localparam int DEPTH = 4;
  localparam int PW    = 2;
  localparam int QCW   = 3;
  localparam int MW    = $clog2(MAX_ROWS + 1);
  localparam int NW    = $clog2(MAX_COLUMNS + 1);

  queue_item_t      slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [QCW-1:0]   count;
  logic [QCW-1:0]   count_next;
  logic [MW-1:0]    m;
  logic [NW-1:0]    n;
  logic             push;
  logic             pop;
  queue_item_t      classified;

  assign m = (32'(cfg.row_total) > 32'(MAX_ROWS)) ? MW'(MAX_ROWS) : MW'(cfg.row_total);
  assign n = (32'(cfg.column_total) > 32'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS)
                                                        : NW'(cfg.column_total);

  assign item_stall = (count == QCW'(DEPTH)) || clearing;
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != '0);
  assign pop        = q_pop && q_valid;
  assign q_item     = slots[rd_ptr];

  always_comb begin
    classified.store = item.has_entry && (32'(item.entry_row) < 32'(m)) &&
                       (32'(item.entry_column) < 32'(n));
    classified.row   = item.entry_row;
    classified.col   = item.entry_column;
    classified.skip  = item.column_skipped;
    classified.last  = item.last;
  end

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

endmodule

[sv/nenc_back.sv]
// engine: entry store, bound passes, exact row walk and result register
module nenc_back import nenc_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  queue_item_t q_item,
  output logic        q_pop,
  output logic        clearing,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int EAW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int MW    = $clog2(MAX_ROWS + 1);
  localparam int NW    = $clog2(MAX_COLUMNS + 1);
  localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
  localparam int PRODW = 2 * CNTW;
  localparam int FW    = 2 * MW;
  localparam int BW0   = (PRODW > FW) ? PRODW : FW;
  localparam int BW    = ((BW0 > CAP_W) ? BW0 : CAP_W) + 1;
  localparam int MKW   = RIW + 1;

  localparam logic [5:0] S_CLR    = 6'd0;
  localparam logic [5:0] S_IDLE   = 6'd1;
  localparam logic [5:0] S_LOAD   = 6'd2;
  localparam logic [5:0] S_SCAN_A = 6'd3;
  localparam logic [5:0] S_SCAN_B = 6'd4;
  localparam logic [5:0] S_ADD    = 6'd5;
  localparam logic [5:0] S_LAST   = 6'd6;
  localparam logic [5:0] S_CNT_A  = 6'd7;
  localparam logic [5:0] S_CNT_B  = 6'd8;
  localparam logic [5:0] S_CNT_C  = 6'd9;
  localparam logic [5:0] S_SUM_A  = 6'd10;
  localparam logic [5:0] S_SUM_B  = 6'd11;
  localparam logic [5:0] S_SUM_C  = 6'd12;
  localparam logic [5:0] S_SUM_D  = 6'd13;
  localparam logic [5:0] S_BND_A  = 6'd14;
  localparam logic [5:0] S_BND_B  = 6'd15;
  localparam logic [5:0] S_DEC    = 6'd16;
  localparam logic [5:0] S_RCLR   = 6'd17;
  localparam logic [5:0] S_F1_A   = 6'd18;
  localparam logic [5:0] S_F1_B   = 6'd19;
  localparam logic [5:0] S_F1_C   = 6'd20;
  localparam logic [5:0] S_RP_A   = 6'd21;
  localparam logic [5:0] S_RP_B   = 6'd22;
  localparam logic [5:0] S_F2_A   = 6'd23;
  localparam logic [5:0] S_F2_B   = 6'd24;
  localparam logic [5:0] S_F2_C   = 6'd25;
  localparam logic [5:0] S_X_ROW  = 6'd26;
  localparam logic [5:0] S_X_PS   = 6'd27;
  localparam logic [5:0] S_X_PE   = 6'd28;
  localparam logic [5:0] S_X_P    = 6'd29;
  localparam logic [5:0] S_X_J    = 6'd30;
  localparam logic [5:0] S_X_QS   = 6'd31;
  localparam logic [5:0] S_X_QE   = 6'd32;
  localparam logic [5:0] S_X_Q    = 6'd33;
  localparam logic [5:0] S_X_R    = 6'd34;
  localparam logic [5:0] S_X_M    = 6'd35;
  localparam logic [5:0] S_X_CHK  = 6'd36;
  localparam logic [5:0] S_OUT    = 6'd37;

  // memories
  logic [RIW+CIW-1:0] entry_mem [MAX_ENTRIES];
  logic [CNTW-1:0]    cnt_mem   [MAX_COLUMNS];
  logic               skip_mem  [MAX_COLUMNS];
  logic [CNTW-1:0]    cs_mem    [MAX_COLUMNS+1];
  logic [RIW-1:0]     cr_mem    [MAX_ENTRIES];
  logic [CNTW-1:0]    rs_mem    [MAX_ROWS+1];
  logic [CNTW-1:0]    rcur_mem  [MAX_ROWS];
  logic [CIW-1:0]     rcol_mem  [MAX_ENTRIES];
  logic [MKW-1:0]     mk_mem    [MAX_ROWS];

  logic               entry_we;
  logic [RIW+CIW-1:0] entry_rd;
  logic               cnt_we;
  logic [CIW-1:0]     cnt_wa, cnt_ra;
  logic [CNTW-1:0]    cnt_wd, cnt_rd;
  logic               skip_we;
  logic [CIW-1:0]     skip_wa, skip_ra;
  logic               skip_wd, skip_rd;
  logic               cs_we;
  logic [NW-1:0]      cs_wa, cs_ra;
  logic [CNTW-1:0]    cs_wd, cs_rd;
  logic               cr_we;
  logic [EAW-1:0]     cr_wa, cr_ra;
  logic [RIW-1:0]     cr_wd, cr_rd;
  logic               rs_we;
  logic [MW-1:0]      rs_wa, rs_ra;
  logic [CNTW-1:0]    rs_wd, rs_rd;
  logic               rcur_we;
  logic [RIW-1:0]     rcur_wa, rcur_ra;
  logic [CNTW-1:0]    rcur_wd, rcur_rd;
  logic               rcol_we;
  logic [EAW-1:0]     rcol_wa, rcol_ra;
  logic [CIW-1:0]     rcol_wd, rcol_rd;
  logic               mk_we;
  logic [RIW-1:0]     mk_wa, mk_ra;
  logic [MKW-1:0]     mk_wd, mk_rd;

  // control and working registers
  logic [5:0]        state;
  queue_item_t       cur;
  logic [CNTW-1:0]   fill;
  logic [CNTW-1:0]   e_idx;
  logic [CIW-1:0]    jc;
  logic [NW-1:0]     j;
  logic [CNTW-1:0]   prefix;
  logic [CNTW-1:0]   c_op;
  logic [PRODW-1:0]  prod;
  logic [PRODW-1:0]  sum;
  logic [PRODW-1:0]  largest;
  logic [FW-1:0]     full_prod;
  logic [BW-1:0]     lower;
  logic [BW-1:0]     upper;
  logic [MW-1:0]     k;
  logic [CNTW-1:0]   acc;
  logic [MW-1:0]     i;
  logic [CNTW-1:0]   p, pe, q, qe;
  logic [CIW-1:0]    jj;
  logic [RIW-1:0]    rr;
  logic [MW-1:0]     rcount;
  logic [BW-1:0]     count;
  result_t           pend;
  result_t           res;
  logic              res_valid;

  logic [MW-1:0]     m;
  logic [NW-1:0]     n;
  logic [BW-1:0]     cap;
  logic [RIW-1:0]    e_row;
  logic [CIW-1:0]    e_col;
  logic              e_in;
  logic              e_more;
  logic [PRODW-1:0]  strict;
  logic [BW-1:0]     plain_upper;
  logic [BW-1:0]     full_half;
  logic [CNTW-1:0]   acc_next;
  logic              hit;
  logic              out_load;

  assign m = (32'(cfg.row_total) > 32'(MAX_ROWS)) ? MW'(MAX_ROWS) : MW'(cfg.row_total);
  assign n = (32'(cfg.column_total) > 32'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS)
                                                        : NW'(cfg.column_total);
  assign cap         = BW'(cfg.cap_limit);
  assign e_row       = entry_rd[RIW+CIW-1:CIW];
  assign e_col       = entry_rd[CIW-1:0];
  assign e_in        = (e_row < m) && (e_col < n);
  assign e_more      = (e_idx + 1'b1) < fill;
  assign strict      = prod >> 1;
  assign plain_upper = BW'(m) + BW'(sum);
  assign full_half   = BW'(full_prod >> 1);
  assign acc_next    = acc + rs_rd;
  assign hit         = (rr > i) && (mk_rd != MKW'(i));
  assign out_load    = (state == S_OUT) && (!res_valid || !result_stall);

  assign q_pop        = (state == S_IDLE) && q_valid;
  assign clearing     = (state == S_CLR);
  assign result_valid = res_valid;
  assign result       = res;

  always_comb begin
    entry_we = 1'b0;
    cnt_we   = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
    skip_we  = 1'b0; skip_wa = '0; skip_wd = 1'b0; skip_ra = '0;
    cs_we    = 1'b0; cs_wa = '0; cs_wd = '0; cs_ra = '0;
    cr_we    = 1'b0; cr_wa = '0; cr_wd = '0; cr_ra = '0;
    rs_we    = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra = '0;
    rcur_we  = 1'b0; rcur_wa = '0; rcur_wd = '0; rcur_ra = '0;
    rcol_we  = 1'b0; rcol_wa = '0; rcol_wd = '0; rcol_ra = '0;
    mk_we    = 1'b0; mk_wa = '0; mk_wd = '0; mk_ra = '0;
    case (state)
      S_CLR: begin
        cnt_we  = 1'b1; cnt_wa = jc; cnt_wd = '0;
        skip_we = 1'b1; skip_wa = jc; skip_wd = 1'b0;
      end
      S_LOAD: begin
        skip_we = cur.store;
        skip_wa = CIW'(cur.col);
        skip_wd = cur.skip;
      end
      S_ADD: begin
        entry_we = (fill < CNTW'(MAX_ENTRIES));
      end
      S_CNT_B: begin
        cnt_ra = e_col;
      end
      S_CNT_C: begin
        cnt_we = 1'b1; cnt_wa = e_col; cnt_wd = cnt_rd + 1'b1;
      end
      S_SUM_A: begin
        if (j == n) begin
          cs_we = 1'b1; cs_wa = j; cs_wd = prefix;
        end else begin
          cnt_ra  = CIW'(j);
          skip_ra = CIW'(j);
        end
      end
      S_SUM_B: begin
        cs_we  = 1'b1; cs_wa = j; cs_wd = prefix;
        cnt_we = 1'b1; cnt_wa = CIW'(j); cnt_wd = prefix;
      end
      S_RCLR: begin
        rs_we = 1'b1; rs_wa = k; rs_wd = '0;
        mk_we = (k < MW'(MAX_ROWS)); mk_wa = RIW'(k); mk_wd = '1;
      end
      S_F1_B: begin
        cnt_ra = e_col;
        rs_ra  = MW'(e_row) + 1'b1;
      end
      S_F1_C: begin
        cr_we  = 1'b1; cr_wa = cnt_rd[EAW-1:0]; cr_wd = e_row;
        cnt_we = 1'b1; cnt_wa = e_col; cnt_wd = cnt_rd + 1'b1;
        rs_we  = 1'b1; rs_wa = MW'(e_row) + 1'b1; rs_wd = rs_rd + 1'b1;
      end
      S_RP_A: begin
        rs_ra = k;
      end
      S_RP_B: begin
        rs_we   = 1'b1; rs_wa = k; rs_wd = acc_next;
        rcur_we = (k < m); rcur_wa = RIW'(k); rcur_wd = acc_next;
      end
      S_F2_B: begin
        rcur_ra = e_row;
      end
      S_F2_C: begin
        rcol_we = 1'b1; rcol_wa = rcur_rd[EAW-1:0]; rcol_wd = e_col;
        rcur_we = 1'b1; rcur_wa = e_row; rcur_wd = rcur_rd + 1'b1;
      end
      S_X_ROW: begin
        rs_ra = i;
      end
      S_X_PS: begin
        rs_ra = i + 1'b1;
      end
      S_X_P: begin
        rcol_ra = p[EAW-1:0];
      end
      S_X_J: begin
        skip_ra = rcol_rd;
        cs_ra   = NW'(rcol_rd);
      end
      S_X_QS: begin
        cs_ra = NW'(jj) + 1'b1;
      end
      S_X_Q: begin
        cr_ra = q[EAW-1:0];
      end
      S_X_R: begin
        mk_ra = cr_rd;
      end
      S_X_M: begin
        mk_we = hit; mk_wa = rr; mk_wd = MKW'(i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[fill[EAW-1:0]] <= {RIW'(cur.row), CIW'(cur.col)};
    end
    entry_rd <= entry_mem[e_idx[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (skip_we) begin
      skip_mem[skip_wa] <= skip_wd;
    end
    skip_rd <= skip_mem[skip_ra];
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_wa] <= cs_wd;
    end
    cs_rd <= cs_mem[cs_ra];
  end

  always_ff @(posedge clk) begin
    if (cr_we) begin
      cr_mem[cr_wa] <= cr_wd;
    end
    cr_rd <= cr_mem[cr_ra];
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= rs_wd;
    end
    rs_rd <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (rcur_we) begin
      rcur_mem[rcur_wa] <= rcur_wd;
    end
    rcur_rd <= rcur_mem[rcur_ra];
  end

  always_ff @(posedge clk) begin
    if (rcol_we) begin
      rcol_mem[rcol_wa] <= rcol_wd;
    end
    rcol_rd <= rcol_mem[rcol_ra];
  end

  always_ff @(posedge clk) begin
    if (mk_we) begin
      mk_mem[mk_wa] <= mk_wd;
    end
    mk_rd <= mk_mem[mk_ra];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!result_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= pend;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      jc    <= '0;
      fill  <= '0;
    end else begin
      case (state)
        S_CLR: begin
          if (jc == CIW'(MAX_COLUMNS - 1)) begin
            fill  <= '0;
            state <= S_IDLE;
          end else begin
            jc <= jc + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          e_idx <= '0;
          if (!cur.store) begin
            state <= S_LAST;
          end else if (fill == '0) begin
            state <= S_ADD;
          end else begin
            state <= S_SCAN_A;
          end
        end
        S_SCAN_A: begin
          state <= S_SCAN_B;
        end
        S_SCAN_B: begin
          if (entry_rd == {RIW'(cur.row), CIW'(cur.col)}) begin
            state <= S_LAST;
          end else if (e_more) begin
            e_idx <= e_idx + 1'b1;
            state <= S_SCAN_A;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (fill < CNTW'(MAX_ENTRIES)) begin
            fill <= fill + 1'b1;
          end
          state <= S_LAST;
        end
        S_LAST: begin
          e_idx   <= '0;
          j       <= '0;
          prefix  <= '0;
          sum     <= '0;
          largest <= '0;
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (fill == '0) begin
            state <= S_SUM_A;
          end else begin
            state <= S_CNT_A;
          end
        end
        S_CNT_A: begin
          state <= S_CNT_B;
        end
        S_CNT_B, S_CNT_C: begin
          if (state == S_CNT_B && e_in) begin
            state <= S_CNT_C;
          end else if (e_more) begin
            e_idx <= e_idx + 1'b1;
            state <= S_CNT_A;
          end else begin
            state <= S_SUM_A;
          end
        end
        S_SUM_A: begin
          state <= (j == n) ? S_BND_A : S_SUM_B;
        end
        S_SUM_B: begin
          prefix <= prefix + cnt_rd;
          c_op   <= skip_rd ? '0 : cnt_rd;
          state  <= S_SUM_C;
        end
        S_SUM_C: begin
          prod  <= PRODW'(c_op) * PRODW'(CNTW'(c_op - 1'b1));
          state <= S_SUM_D;
        end
        S_SUM_D: begin
          sum <= sum + strict;
          if (strict > largest) begin
            largest <= strict;
          end
          j     <= j + 1'b1;
          state <= S_SUM_A;
        end
        S_BND_A: begin
          full_prod <= FW'(m) * (FW'(m) + 1'b1);
          state     <= S_BND_B;
        end
        S_BND_B: begin
          lower <= BW'(m) + BW'(largest);
          upper <= (plain_upper < full_half) ? plain_upper : full_half;
          state <= S_DEC;
        end
        S_DEC: begin
          k <= '0;
          if (cfg.cap_enabled && lower > cap) begin
            pend  <= '{nonzeros: lower[NZ_W-1:0], cap_exceeded: 1'b1, exact: 1'b0};
            state <= S_OUT;
          end else if (!cfg.cap_enabled || upper <= cap) begin
            pend  <= '{nonzeros: upper[NZ_W-1:0], cap_exceeded: 1'b0,
                       exact: (lower == upper)};
            state <= S_OUT;
          end else begin
            state <= S_RCLR;
          end
        end
        S_RCLR: begin
          if (k == MW'(MAX_ROWS)) begin
            e_idx <= '0;
            k     <= '0;
            acc   <= '0;
            state <= (fill == '0) ? S_RP_A : S_F1_A;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_F1_A: begin
          state <= S_F1_B;
        end
        S_F1_B, S_F1_C: begin
          if (state == S_F1_B && e_in) begin
            state <= S_F1_C;
          end else if (e_more) begin
            e_idx <= e_idx + 1'b1;
            state <= S_F1_A;
          end else begin
            state <= S_RP_A;
          end
        end
        S_RP_A: begin
          state <= S_RP_B;
        end
        S_RP_B: begin
          acc <= acc_next;
          if (k == m) begin
            e_idx <= '0;
            i     <= '0;
            count <= '0;
            state <= (fill == '0) ? S_X_ROW : S_F2_A;
          end else begin
            k     <= k + 1'b1;
            state <= S_RP_A;
          end
        end
        S_F2_A: begin
          state <= S_F2_B;
        end
        S_F2_B, S_F2_C: begin
          if (state == S_F2_B && e_in) begin
            state <= S_F2_C;
          end else if (e_more) begin
            e_idx <= e_idx + 1'b1;
            state <= S_F2_A;
          end else begin
            state <= S_X_ROW;
          end
        end
        S_X_ROW: begin
          rcount <= MW'(1);
          if (i == m) begin
            pend  <= '{nonzeros: count[NZ_W-1:0], cap_exceeded: 1'b0, exact: 1'b1};
            state <= S_OUT;
          end else begin
            state <= S_X_PS;
          end
        end
        S_X_PS: begin
          p     <= rs_rd;
          state <= S_X_PE;
        end
        S_X_PE: begin
          pe    <= rs_rd;
          state <= S_X_P;
        end
        S_X_P: begin
          if (p == pe) begin
            count <= count + BW'(rcount);
            state <= S_X_CHK;
          end else begin
            state <= S_X_J;
          end
        end
        S_X_J: begin
          jj    <= rcol_rd;
          state <= S_X_QS;
        end
        S_X_QS: begin
          if (skip_rd) begin
            p     <= p + 1'b1;
            state <= S_X_P;
          end else begin
            q     <= cs_rd;
            state <= S_X_QE;
          end
        end
        S_X_QE: begin
          qe    <= cs_rd;
          state <= S_X_Q;
        end
        S_X_Q: begin
          if (q == qe) begin
            p     <= p + 1'b1;
            state <= S_X_P;
          end else begin
            state <= S_X_R;
          end
        end
        S_X_R: begin
          rr    <= cr_rd;
          state <= S_X_M;
        end
        S_X_M: begin
          if (hit) begin
            rcount <= rcount + 1'b1;
          end
          q     <= q + 1'b1;
          state <= S_X_Q;
        end
        S_X_CHK: begin
          if (count > cap) begin
            pend  <= '{nonzeros: count[NZ_W-1:0], cap_exceeded: 1'b1, exact: 1'b0};
            state <= S_OUT;
          end else begin
            i     <= i + 1'b1;
            state <= S_X_ROW;
          end
        end
        S_OUT: begin
          if (out_load) begin
            jc    <= '0;
            state <= S_CLR;
          end
        end
        default: begin
          jc    <= '0;
          state <= S_CLR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur <= q_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNTW'(MAX_ENTRIES)) else $error("entry fill beyond store depth");
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_valid && result_stall) |=> (state == S_OUT))
    else $error("result issued over a waiting one");
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> (state == S_CLR && jc == '0)) else $error("no clearing sweep after reset");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.cap_exceeded && res.exact)) else $error("over cap result marked exact");
`endif

endmodule

[sv/normal_equations_nonzero_count.sv]
// Predicts the lower-triangle nonzero count of A*A^T from streamed sparse entries. An entry item
// is accepted whenever the queue has room; the engine then checks it against the stored
// entries one at a time and adds it to the store if none matches and the store has room.
// The item marked last starts the computation: a count pass over the entries, a column pass
// over the columns and, when the cap falls between the bounds, a clearing sweep of the
// MAX_ROWS+1 row slots, three list-building passes and the row walk, which steps through each
// row, each of its entries and each column entry visited. After reset and after each result a
// sweep over all MAX_COLUMNS columns clears the column counts and skip flags; no item is accepted meanwhile.
module normal_equations_nonzero_count import nenc_pkg::*; #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t        cfg;
  logic        q_valid;
  queue_item_t q_item;
  logic        q_pop;
  logic        clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_total    <= ROW_TOTAL_RESET;
      cfg.column_total <= COLUMN_TOTAL_RESET;
      cfg.cap_enabled  <= 1'b0;
      cfg.cap_limit    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_TOTAL:    cfg.row_total    <= cfg_data[TOTAL_W-1:0];
        REG_COLUMN_TOTAL: cfg.column_total <= cfg_data[TOTAL_W-1:0];
        REG_CAP_ENABLED:  cfg.cap_enabled  <= cfg_data[0];
        REG_CAP_LIMIT:    cfg.cap_limit    <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nenc_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  nenc_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
